@@ rtl/uart_frame_checker_macros.svh @@
// ---------------------------------------------------------------------------
// uart_frame_checker assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ---------------------------------------------------------------------------
`ifndef UART_FRAME_CHECKER_MACROS_SVH
`define UART_FRAME_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("uart_frame_checker assertion failed");
`define UFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("uart_frame_checker assertion failed");
`else
`define UFC_ASSERT(lbl, clk, rstn, prop)
`define UFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/ufc_pkg.sv @@
// ---------------------------------------------------------------------------
// ufc_pkg
// Shared types, constants and the byte-wide CRC-16/MODBUS update.
// ---------------------------------------------------------------------------
package ufc_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_LEN = 1'd1;

  localparam logic [7:0]  SYNC_BYTE_RST    = 8'd170;
  localparam logic [15:0] MAX_DATA_LEN_RST = 16'd1024;

  localparam logic [15:0] HDR_SEQ_POS  = 16'd3;
  localparam logic [15:0] HDR_FUNC_POS = 16'd4;
  localparam logic [15:0] HDR_LENH_POS = 16'd5;
  localparam logic [15:0] HDR_LENL_POS = 16'd6;
  localparam logic [15:0] HDR_CSUM_POS = 16'(HEADER_BYTES - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CSUM  = 2'd1;
  localparam logic [1:0] ST_BAD_CRC   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [15:0] max_data_len;
  } ufc_cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [1:0]  status;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_func;
    logic [15:0] frame_length;
  } ufc_result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/ufc_parser.sv @@
// ---------------------------------------------------------------------------
// ufc_parser
// Frame state machine: header checksum, length check, CRC and payload pass.
// ---------------------------------------------------------------------------
`include "uart_frame_checker_macros.svh"

module ufc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  ufc_pkg::ufc_cfg_t  cfg_i,
  output logic               res_valid_o,
  output ufc_pkg::ufc_result_t res_o
);

  ufc_pkg::phase_e phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] crc_next;
  logic [15:0] cnt_inc;
  logic        res_valid;
  logic        is_hunt, is_header, is_crc, done_push, both_kinds;

  assign crc_next = ufc_pkg::crc_step(crc_q, rx_byte_i);
  assign cnt_inc  = cnt_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    crc_d     = crc_q;
    seq_d     = seq_q;
    func_d    = func_q;
    len_d     = len_q;
    first_d   = first_q;
    res_valid = 1'b0;
    res_o               = '0;
    res_o.frame_seq     = seq_q;
    res_o.frame_func    = func_q;
    res_o.frame_length  = len_q;
    case (phase_q)
      ufc_pkg::PH_HUNT: begin
        if (rx_byte_i == cfg_i.sync_byte) begin
          sum_d   = rx_byte_i;
          crc_d   = ufc_pkg::crc_step(ufc_pkg::CRC_INIT, rx_byte_i);
          cnt_d   = 16'd1;
          seq_d   = '0;
          func_d  = '0;
          len_d   = '0;
          phase_d = ufc_pkg::PH_HEADER;
        end
      end
      ufc_pkg::PH_HEADER: begin
        if (cnt_q < ufc_pkg::HDR_CSUM_POS) begin
          if (cnt_q == ufc_pkg::HDR_SEQ_POS) begin
            seq_d = rx_byte_i;
          end else if (cnt_q == ufc_pkg::HDR_FUNC_POS) begin
            func_d = rx_byte_i;
          end else if (cnt_q == ufc_pkg::HDR_LENH_POS) begin
            len_d = {rx_byte_i, len_q[7:0]};
          end else if (cnt_q == ufc_pkg::HDR_LENL_POS) begin
            len_d = {len_q[15:8], rx_byte_i};
          end
          sum_d = sum_q + rx_byte_i;
          crc_d = crc_next;
          cnt_d = cnt_inc;
        end else if (rx_byte_i != (8'd0 - sum_q)) begin
          phase_d          = ufc_pkg::PH_HUNT;
          cnt_d            = '0;
          res_valid        = 1'b1;
          res_o.frame_done = 1'b1;
          res_o.status     = ufc_pkg::ST_BAD_CSUM;
        end else if (len_q > cfg_i.max_data_len) begin
          phase_d          = ufc_pkg::PH_HUNT;
          cnt_d            = '0;
          res_valid        = 1'b1;
          res_o.frame_done = 1'b1;
          res_o.status     = ufc_pkg::ST_TOO_LONG;
        end else begin
          crc_d   = crc_next;
          cnt_d   = '0;
          phase_d = (len_q == 16'd0) ? ufc_pkg::PH_CRC : ufc_pkg::PH_PAYLOAD;
        end
      end
      ufc_pkg::PH_PAYLOAD: begin
        crc_d = crc_next;
        if (cnt_inc >= len_q) begin
          cnt_d   = '0;
          phase_d = ufc_pkg::PH_CRC;
        end else begin
          cnt_d = cnt_inc;
        end
        res_valid           = 1'b1;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
      end
      ufc_pkg::PH_CRC: begin
        if (cnt_q == 16'd0) begin
          first_d = rx_byte_i;
          cnt_d   = 16'd1;
        end else begin
          phase_d          = ufc_pkg::PH_HUNT;
          cnt_d            = '0;
          res_valid        = 1'b1;
          res_o.frame_done = 1'b1;
          res_o.status     = ({rx_byte_i, first_q} == crc_q) ? ufc_pkg::ST_OK
                                                              : ufc_pkg::ST_BAD_CRC;
        end
      end
      default: begin
        phase_d = ufc_pkg::PH_HUNT;
        cnt_d   = '0;
      end
    endcase
  end

  assign res_valid_o = accept_i & res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ufc_pkg::PH_HUNT;
      cnt_q   <= '0;
      sum_q   <= '0;
      crc_q   <= ufc_pkg::CRC_INIT;
      seq_q   <= '0;
      func_q  <= '0;
      len_q   <= '0;
      first_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      crc_q   <= crc_d;
      seq_q   <= seq_d;
      func_q  <= func_d;
      len_q   <= len_d;
      first_q <= first_d;
    end
  end

  assign is_hunt    = (phase_q == ufc_pkg::PH_HUNT);
  assign is_header  = (phase_q == ufc_pkg::PH_HEADER);
  assign is_crc     = (phase_q == ufc_pkg::PH_CRC);
  assign done_push  = res_valid_o & res_o.frame_done;
  assign both_kinds = res_o.payload_valid & res_o.frame_done;

  `UFC_ASSERT(a_done_returns_to_hunt, clk_i, rst_ni, done_push |=> is_hunt)
  `UFC_ASSERT(a_hdr_cnt_range, clk_i, rst_ni, is_header |-> (cnt_q <= ufc_pkg::HDR_CSUM_POS))
  `UFC_ASSERT(a_crc_cnt_range, clk_i, rst_ni, is_crc |-> (cnt_q <= 16'd1))
  `UFC_ASSERT(a_payload_not_done, clk_i, rst_ni, res_valid_o |-> !both_kinds)

endmodule

@@ rtl/ufc_out_stage.sv @@
// ---------------------------------------------------------------------------
// ufc_out_stage
// Output register with skid slot; decouples input ready from output stalls.
// ---------------------------------------------------------------------------
`include "uart_frame_checker_macros.svh"

module ufc_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ufc_pkg::ufc_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ufc_pkg::ufc_result_t out_data_o
);

  logic v0_q, v0_d, v1_q, v1_d;
  ufc_pkg::ufc_result_t d0_q, d0_d, d1_q, d1_d;
  logic pop;

  assign pop = v0_q & out_ready_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    if (push_i && !pop) begin
      if (!v0_q) begin
        v0_d = 1'b1;
        d0_d = push_data_i;
      end else begin
        v1_d = 1'b1;
        d1_d = push_data_i;
      end
    end else if (!push_i && pop) begin
      v0_d = v1_q;
      d0_d = d1_q;
      v1_d = 1'b0;
    end else if (push_i && pop) begin
      if (v1_q) begin
        d0_d = d1_q;
        d1_d = push_data_i;
      end else begin
        d0_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

  assign full_o      = v1_q;
  assign out_valid_o = v0_q;
  assign out_data_o  = d0_q;

  `UFC_ASSERT_ALWAYS(a_skid_implies_out, clk_i, v1_q |-> v0_q)
  `UFC_ASSERT(a_no_push_when_full, clk_i, rst_ni, v1_q |-> !push_i)

endmodule

@@ rtl/uart_frame_checker.sv @@
// ---------------------------------------------------------------------------
// uart_frame_checker
// Checks serial frames byte by byte and passes payload bytes and status out.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o   | rx_byte_i
//  out     | out_valid_o/out_ready_i | payload_valid_o .. frame_length_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One byte per cycle while in_ready_o is high; the frame FSM updates in the
//  accept cycle and each result reaches the outputs through the output stage.
//  A two-entry output stage holds results; in_ready_o drops only when both
//  entries are full. Config writes are always ready.
//  Reset (async, active low) returns to hunting with default config.
// ---------------------------------------------------------------------------
module uart_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           payload_valid_o,
  output logic [7:0]                     payload_byte_o,
  output logic                           frame_done_o,
  output logic [1:0]                     status_o,
  output logic [7:0]                     frame_seq_o,
  output logic [7:0]                     frame_func_o,
  output logic [15:0]                    frame_length_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ufc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ufc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ufc_pkg::ufc_cfg_t    cfg_q;
  ufc_pkg::ufc_result_t res, out_data;
  logic in_accept, res_valid, full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte    <= ufc_pkg::SYNC_BYTE_RST;
      cfg_q.max_data_len <= ufc_pkg::MAX_DATA_LEN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ufc_pkg::CFG_SYNC_BYTE:    cfg_q.sync_byte    <= cfg_data_i[7:0];
        ufc_pkg::CFG_MAX_DATA_LEN: cfg_q.max_data_len <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = ~full;
  assign in_accept  = in_valid_i & in_ready_o;

  ufc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ufc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign payload_valid_o = out_data.payload_valid;
  assign payload_byte_o  = out_data.payload_byte;
  assign frame_done_o    = out_data.frame_done;
  assign status_o        = out_data.status;
  assign frame_seq_o     = out_data.frame_seq;
  assign frame_func_o    = out_data.frame_func;
  assign frame_length_o  = out_data.frame_length;

endmodule
